[sv/relay_bank_auto_off_controller_assert.svh]
// ----------------------------------------------------------------------------
// Relay bank assertion macros
// Shorthand for clocked checks on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef RELAY_BANK_AUTO_OFF_CONTROLLER_ASSERT_SVH
`define RELAY_BANK_AUTO_OFF_CONTROLLER_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define RBAC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("relay bank check failed");

// consequent holds in the cycle after the antecedent
`define RBAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("relay bank check failed");

`endif

[sv/rbac_pkg.sv]
// ----------------------------------------------------------------------------
// rbac_pkg
// Shared types, codes and helpers of the relay bank auto-off controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rbac_pkg;

  localparam int RELAY_COUNT_DEF = 4;

  localparam int unsigned MS_PER_HOUR = 3600000;
  localparam int unsigned MIN_CMD_LEN = 7;
  // quotient of a 32-bit ms count by one hour fits in 11 bits
  localparam int QUO_W = 11;

  // one hour is 2^7 * 28125: drop 7 bits, then multiply by ceil(2^40 / 28125)
  localparam int HOUR_PRE    = 7;
  localparam int DIVD_W      = 32 - HOUR_PRE;
  localparam int RECIP_W     = 26;
  localparam int RECIP_SHIFT = 40;
  localparam int PROD_W      = DIVD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] HOUR_RECIP = 26'd39093747;

  // input kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_SYNC = 2'd2;
  localparam logic [1:0] KIND_PING = 2'd3;

  // result kinds
  localparam logic [1:0] RK_ACK      = 2'd0;
  localparam logic [1:0] RK_PONG     = 2'd1;
  localparam logic [1:0] RK_ANNOUNCE = 2'd2;

  // register indexes
  localparam logic [1:0] REG_GATEWAY  = 2'd0;
  localparam logic [1:0] REG_MAX_ON   = 2'd1;
  localparam logic [1:0] REG_ANNOUNCE = 2'd2;
  localparam logic [1:0] REG_LINK     = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [1:0] {
    CMD_ON      = 2'd0,
    CMD_OFF     = 2'd1,
    CMD_TOGGLE  = 2'd2,
    CMD_UNKNOWN = 2'd3
  } cmd_e;

  // broadcast from the sequencer to every relay cell
  typedef struct packed {
    logic        tick;
    logic        cmd;
    logic        sync;
    logic        link_ready;
    cmd_e        op;
    logic [30:0] dur;
    logic [31:0] now;
  } cell_ctl_t;

  // wrap-safe: (now - start) as signed 32 bits is non-negative and >= limit
  function automatic logic reached(input logic [31:0] now, input logic [31:0] start,
                                   input logic [30:0] limit);
    logic [31:0] diff;
    diff = now - start;
    return !diff[31] && (diff[30:0] >= limit);
  endfunction

endpackage

`default_nettype wire

[sv/rbac_cell.sv]
// ----------------------------------------------------------------------------
// rbac_cell
// One relay: on bit, timer, ack flag and a stage of the scan token chain.
// ----------------------------------------------------------------------------
`default_nettype none

module rbac_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rbac_pkg::cell_ctl_t ctl_i,
  input  wire logic                sel_i,
  input  wire logic                shift_i,
  input  wire logic                tok_i,
  output logic                     tok_o,
  output logic                     flag_o,
  output logic                     on_o
);
  import rbac_pkg::*;

  logic        on_q, on_d;
  logic [31:0] start_q, start_d;
  logic [30:0] auto_q, auto_d;
  logic        flag_q, flag_d;
  logic        tok_q, tok_d;
  logic        next_on;

  always_comb begin
    on_d    = on_q;
    start_d = start_q;
    auto_d  = auto_q;
    flag_d  = flag_q;
    next_on = !on_q;

    if (ctl_i.tick && on_q && (auto_q != '0) && reached(ctl_i.now, start_q, auto_q)) begin
      on_d   = 1'b0;
      auto_d = '0;
      flag_d = ctl_i.link_ready;
    end

    if (ctl_i.cmd && sel_i) begin
      case (ctl_i.op)
        CMD_ON: begin
          on_d = 1'b1;
          if (ctl_i.dur != '0) begin
            auto_d  = ctl_i.dur;
            start_d = ctl_i.now;
          end
        end
        CMD_OFF: begin
          on_d   = 1'b0;
          auto_d = '0;
        end
        CMD_TOGGLE: begin
          on_d = next_on;
          if (next_on && (ctl_i.dur != '0)) begin
            auto_d  = ctl_i.dur;
            start_d = ctl_i.now;
          end else begin
            auto_d = '0;
          end
        end
        default: ;
      endcase
      flag_d = ctl_i.link_ready;
    end

    if (ctl_i.sync) flag_d = ctl_i.link_ready;

    // ack goes out as the token leaves this cell
    if (tok_q && shift_i) flag_d = 1'b0;

    tok_d = shift_i ? tok_i : tok_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q    <= 1'b0;
      start_q <= '0;
      auto_q  <= '0;
      flag_q  <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      on_q    <= on_d;
      start_q <= start_d;
      auto_q  <= auto_d;
      flag_q  <= flag_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o  = tok_q;
  assign flag_o = flag_q;
  assign on_o   = on_q;

endmodule

`default_nettype wire

[sv/rbac_hour_div.sv]
// ----------------------------------------------------------------------------
// rbac_hour_div
// Division of a ms count by one hour through a reciprocal multiply; the quotient is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rbac_hour_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  // ms count with its low HOUR_PRE bits dropped
  input  wire logic [rbac_pkg::DIVD_W-1:0] dividend_i,
  output logic                             done_o,
  output logic [rbac_pkg::QUO_W-1:0]       quo_o
);
  import rbac_pkg::*;

  logic              done_q, done_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [PROD_W-1:0] prod;

  always_comb begin
    prod   = PROD_W'(dividend_i) * PROD_W'(HOUR_RECIP);
    done_d = start_i;
    quo_d  = start_i ? prod[RECIP_SHIFT +: QUO_W] : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

[sv/relay_bank_auto_off_controller.sv]
// ----------------------------------------------------------------------------
// relay_bank_auto_off_controller
// Relay bank with per-relay auto-off timers, acks, pong and periodic announce.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------------
//  in      | in_valid_i / in_ready_o    | kind .. now_ms
//  out     | out_valid_o / out_ready_i  | result_kind .. last
//  cfg     | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
//  Tick, command and sync: accept, update, scan of every relay, then announce,
//  the scan token walking the cell chain one relay per cycle.
//  Ping: accept, update, the multiply, then the pong.
//  A full output register stops the token (or the pong/announce) in place.
//  No clearing pass after reset; the item is taken only in the idle state.
// ----------------------------------------------------------------------------
`default_nettype none

module relay_bank_auto_off_controller #(
  parameter int RELAY_COUNT = rbac_pkg::RELAY_COUNT_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      kind_i,
  input  wire logic [15:0]                     source_address_i,
  input  wire logic [7:0]                      frame_length_i,
  input  wire logic [7:0]                      relay_index_i,
  input  wire logic [1:0]                      command_i,
  input  wire logic [31:0]                     duration_ms_i,
  input  wire logic [31:0]                     now_ms_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [1:0]                           result_kind_o,
  output logic [1:0]                           acked_relay_o,
  output logic                                 acked_state_o,
  output logic [15:0]                          uptime_hours_o,
  output logic [3:0]                           relay_drive_o,
  output logic                                 blink_o,
  output logic                                 last_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [rbac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rbac_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  `include "relay_bank_auto_off_controller_assert.svh"
  import rbac_pkg::*;

  localparam int IDX_W = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EVAL = 6'b000010,
    ST_SCAN = 6'b000100,
    ST_ANN  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_PONG = 6'b100000
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE = 3'b000,
    OP_TICK = 3'b001,
    OP_CMD  = 3'b010,
    OP_SYNC = 3'b011,
    OP_PING = 3'b100
  } op_e;

  state_e state_q, state_d;

  // configuration
  logic [15:0] gateway_q;
  logic [30:0] max_on_q;
  logic [30:0] interval_q;
  logic        link_q;

  // accepted word
  op_e              op_q, op_d;
  cmd_e             cmd_q;
  logic [IDX_W-1:0] rid_q;
  logic [30:0]      dur_q;
  logic [31:0]      now_q;

  logic [31:0] last_ann_q;
  logic        ann_pend_q, ann_pend_d;

  logic msg_ok;
  logic in_take;

  // cell chain
  cell_ctl_t              ctl;
  logic [RELAY_COUNT-1:0] tok, flags, on_vec, tok_in, sel;
  logic                   start_scan, advance, shift, any_hit;

  // divider
  logic             div_start, div_done;
  logic [QUO_W-1:0] quo;

  // result staging
  logic             out_free, emit;
  logic [1:0]       em_kind, em_relay;
  logic             em_state, em_blink, em_last;
  logic [15:0]      em_uptime;
  logic [IDX_W-1:0] tok_idx;
  logic [3:0]       drive;

  logic        out_valid_q;
  logic [1:0]  out_kind_q, out_relay_q;
  logic        out_state_q, out_blink_q, out_last_q;
  logic [15:0] out_uptime_q;
  logic [3:0]  out_drive_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_take    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // ---- configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gateway_q  <= '0;
      max_on_q   <= 31'(MS_PER_HOUR);
      interval_q <= 31'd60000;
      link_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GATEWAY:  gateway_q  <= cfg_wdata_i[15:0];
        REG_MAX_ON:   max_on_q   <= cfg_wdata_i;
        REG_ANNOUNCE: interval_q <= cfg_wdata_i;
        REG_LINK:     link_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---- decode of the incoming word
  always_comb begin
    msg_ok = (frame_length_i != '0) && (source_address_i == gateway_q);
    op_d   = OP_NONE;
    case (kind_i)
      KIND_TICK: op_d = OP_TICK;
      KIND_CMD: begin
        if (msg_ok && (frame_length_i >= 8'(MIN_CMD_LEN))
            && (relay_index_i < 8'(RELAY_COUNT))) op_d = OP_CMD;
      end
      KIND_SYNC: if (msg_ok) op_d = OP_SYNC;
      KIND_PING: if (msg_ok) op_d = OP_PING;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_NONE;
    end else if (in_take) begin
      op_q <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= cmd_e'(command_i);
      rid_q <= relay_index_i[IDX_W-1:0];
      dur_q <= (duration_ms_i > {1'b0, max_on_q}) ? max_on_q : duration_ms_i[30:0];
      now_q <= now_ms_i;
    end
  end

  // ---- cell chain
  always_comb begin
    ctl.tick       = (state_q == ST_EVAL) && (op_q == OP_TICK);
    ctl.cmd        = (state_q == ST_EVAL) && (op_q == OP_CMD);
    ctl.sync       = (state_q == ST_EVAL) && (op_q == OP_SYNC);
    ctl.link_ready = link_q;
    ctl.op         = cmd_q;
    ctl.dur        = dur_q;
    ctl.now        = now_q;
  end

  assign start_scan = (state_q == ST_EVAL) && (op_q != OP_PING) && (op_q != OP_NONE);
  assign any_hit    = |(tok & flags);
  assign advance    = (state_q == ST_SCAN) && (!any_hit || out_free);
  assign shift      = start_scan || advance;

  always_comb begin
    for (int i = 0; i < RELAY_COUNT; i++) begin
      tok_in[i] = (i == 0) ? start_scan : tok[(i > 0) ? i - 1 : 0];
      sel[i]    = (rid_q == IDX_W'(i));
    end
  end

  for (genvar g = 0; g < RELAY_COUNT; g++) begin : g_cell
    rbac_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .sel_i   (sel[g]),
      .shift_i (shift),
      .tok_i   (tok_in[g]),
      .tok_o   (tok[g]),
      .flag_o  (flags[g]),
      .on_o    (on_vec[g])
    );
  end

  // ---- uptime divider
  assign div_start = (state_q == ST_EVAL) && (op_q == OP_PING) && link_q;

  rbac_hour_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (now_q[31:HOUR_PRE]),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  // ---- announce timer
  // pending flag is decided anew for every word; only a tick can raise it
  always_comb begin
    ann_pend_d = ann_pend_q;
    if (state_q == ST_EVAL) begin
      ann_pend_d = ctl.tick && link_q && reached(now_q, last_ann_q, interval_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ann_pend_q <= 1'b0;
      last_ann_q <= '0;
    end else begin
      ann_pend_q <= ann_pend_d;
      if (ctl.tick && ann_pend_d) last_ann_q <= now_q;
    end
  end

  // ---- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_take) state_d = ST_EVAL;
      ST_EVAL: begin
        if (op_q == OP_NONE) state_d = ST_IDLE;
        else if (op_q == OP_PING) state_d = link_q ? ST_DIV : ST_IDLE;
        else state_d = ST_SCAN;
      end
      ST_SCAN: if (advance && tok[RELAY_COUNT-1]) state_d = ST_ANN;
      ST_ANN:  if (!ann_pend_q || out_free) state_d = ST_IDLE;
      ST_DIV:  if (div_done) state_d = ST_PONG;
      ST_PONG: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // ---- result selection
  always_comb begin
    tok_idx = '0;
    drive   = '0;
    for (int i = 0; i < RELAY_COUNT; i++) begin
      if (tok[i]) tok_idx = tok_idx | IDX_W'(i);
    end
    for (int i = 0; i < 4; i++) begin
      if (i < RELAY_COUNT) drive[i] = on_vec[(i < RELAY_COUNT) ? i : 0];
    end
  end

  always_comb begin
    emit      = 1'b0;
    em_kind   = RK_ACK;
    em_relay  = '0;
    em_state  = 1'b0;
    em_uptime = '0;
    em_blink  = 1'b0;
    em_last   = 1'b1;
    case (state_q)
      ST_SCAN: begin
        emit     = any_hit && out_free;
        em_relay = 2'(tok_idx);
        em_state = |(tok & on_vec);
        em_blink = (op_q == OP_CMD);
        em_last  = ((flags & ~tok) == '0) && !ann_pend_q;
      end
      ST_ANN: begin
        emit    = ann_pend_q && out_free;
        em_kind = RK_ANNOUNCE;
      end
      ST_PONG: begin
        emit      = out_free;
        em_kind   = RK_PONG;
        em_uptime = 16'(quo);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q   <= em_kind;
      out_relay_q  <= em_relay;
      out_state_q  <= em_state;
      out_uptime_q <= em_uptime;
      out_drive_q  <= drive;
      out_blink_q  <= em_blink;
      out_last_q   <= em_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_kind_q;
  assign acked_relay_o  = out_relay_q;
  assign acked_state_o  = out_state_q;
  assign uptime_hours_o = out_uptime_q;
  assign relay_drive_o  = out_drive_q;
  assign blink_o        = out_blink_q;
  assign last_o         = out_last_q;

  // ---- checks
  `RBAC_ASSERT_SAME(a_tok_single, 1'b1, $onehot0(tok))
  `RBAC_ASSERT_SAME(a_idle_clean, state_q == ST_IDLE, (flags == '0) && (tok == '0))
  `RBAC_ASSERT_SAME(a_emit_room, emit, !out_valid_q || out_ready_i)
  `RBAC_ASSERT_NEXT(a_div_to_pong, div_done, state_q == ST_PONG)

endmodule

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: relay bank auto-off controller testbench
// Scripted words first, then random traffic over several register settings.
// Every accepted reply is checked against an in-bench model of the relay
// bank; both channels idle at random and the reply side holds off once.
// ----------------------------------------------------------------------------
module tb_top;
  import rbac_pkg::*;

  localparam int RELAYS        = RELAY_COUNT_DEF;
  localparam int SETTLE_CYCLES = 50;    // tick and sync are the slowest words
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 10;
  localparam int PREDICTED     = -1;
  localparam int NO_LINK_WRITE = -1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] src;
    logic [7:0]  flen;
    logic [7:0]  rid;
    cmd_e        cmd;
    logic [31:0] dur;
    logic [31:0] now;
  } relay_msg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  relay;
    logic        state;
    logic [15:0] hours;
    logic [3:0]  drive;
    logic        blink;
    logic        last;
  } reply_t;

  typedef struct {
    int         link_before;
    relay_msg_t msg;
    int         fixed_n;
    reply_t     fixed;
  } script_row_t;

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  in_valid_i       = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            kind_i           = '0;
  logic [15:0]           source_address_i = '0;
  logic [7:0]            frame_length_i   = '0;
  logic [7:0]            relay_index_i    = '0;
  logic [1:0]            command_i        = '0;
  logic [31:0]           duration_ms_i    = '0;
  logic [31:0]           now_ms_i         = '0;
  logic                  out_valid_o;
  logic                  out_ready_i      = 1'b0;
  logic [1:0]            result_kind_o;
  logic [1:0]            acked_relay_o;
  logic                  acked_state_o;
  logic [15:0]           uptime_hours_o;
  logic [3:0]            relay_drive_o;
  logic                  blink_o;
  logic                  last_o;
  logic                  cfg_we_i         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i        = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i      = '0;

  relay_bank_auto_off_controller uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .source_address_i (source_address_i),
    .frame_length_i   (frame_length_i),
    .relay_index_i    (relay_index_i),
    .command_i        (command_i),
    .duration_ms_i    (duration_ms_i),
    .now_ms_i         (now_ms_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .acked_relay_o    (acked_relay_o),
    .acked_state_o    (acked_state_o),
    .uptime_hours_o   (uptime_hours_o),
    .relay_drive_o    (relay_drive_o),
    .blink_o          (blink_o),
    .last_o           (last_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // relay bank model
  logic [15:0]       gw_addr     = 16'd0;
  logic [30:0]       clamp_ms    = 31'd3600000;
  logic [30:0]       announce_ms = 31'd60000;
  logic              link_up     = 1'b1;
  logic [RELAYS-1:0] relay_up    = '0;
  logic [31:0]       armed_at_ms [RELAYS];
  logic [30:0]       off_after_ms[RELAYS];
  logic [31:0]       announced_ms = '0;

  reply_t      step_replies[$];
  reply_t      expected_replies[$];
  script_row_t script[$];
  int          mismatches  = 0;
  int          burst_left  = 0;
  int          hold_asked  = 0;
  logic [31:0] sim_clock_ms = '0;

  initial begin
    for (int i = 0; i < RELAYS; i++) begin
      armed_at_ms[i]  = '0;
      off_after_ms[i] = '0;
    end
  end

  function automatic reply_t make_reply(logic [1:0] kind, logic [1:0] relay, logic state,
                                        logic [15:0] hours, logic [3:0] drive, logic blink,
                                        logic last);
    reply_t r;
    r.kind  = kind;
    r.relay = relay;
    r.state = state;
    r.hours = hours;
    r.drive = drive;
    r.blink = blink;
    r.last  = last;
    return r;
  endfunction

  // signed elapsed time; a negative span (start in the future) never expires
  function automatic bit timer_elapsed(logic [31:0] now, logic [31:0] since,
                                       logic [30:0] span);
    logic signed [31:0] elapsed;
    elapsed = now - since;
    return (elapsed >= 0) && (elapsed >= $signed({1'b0, span}));
  endfunction

  task automatic predict_replies(input relay_msg_t m);
    logic [31:0] dur;
    logic [31:0] hrs;
    logic [1:0]  idx;
    step_replies.delete();
    if (m.kind == KIND_TICK) begin
      for (int i = 0; i < RELAYS; i++) begin
        if (relay_up[i] && off_after_ms[i] != 0 &&
            timer_elapsed(m.now, armed_at_ms[i], off_after_ms[i])) begin
          relay_up[i]     = 1'b0;
          off_after_ms[i] = '0;
          if (link_up)
            step_replies.push_back(make_reply(RK_ACK, 2'(i), 1'b0, '0, '0, 1'b0, 1'b0));
        end
      end
      if (link_up && timer_elapsed(m.now, announced_ms, announce_ms)) begin
        step_replies.push_back(make_reply(RK_ANNOUNCE, '0, 1'b0, '0, '0, 1'b0, 1'b0));
        announced_ms = m.now;
      end
    end else if (m.flen != 0 && m.src == gw_addr) begin
      case (m.kind)
        KIND_CMD: begin
          if (m.flen >= MIN_CMD_LEN && m.rid < RELAYS) begin
            idx = m.rid[1:0];
            dur = (m.dur > {1'b0, clamp_ms}) ? {1'b0, clamp_ms} : m.dur;
            case (m.cmd)
              CMD_ON: begin
                relay_up[idx] = 1'b1;
                if (dur != 0) begin
                  off_after_ms[idx] = dur[30:0];
                  armed_at_ms[idx]  = m.now;
                end
              end
              CMD_OFF: begin
                relay_up[idx]     = 1'b0;
                off_after_ms[idx] = '0;
              end
              CMD_TOGGLE: begin
                relay_up[idx] = !relay_up[idx];
                if (relay_up[idx] && dur != 0) begin
                  off_after_ms[idx] = dur[30:0];
                  armed_at_ms[idx]  = m.now;
                end else begin
                  off_after_ms[idx] = '0;
                end
              end
              default: ;
            endcase
            if (link_up)
              step_replies.push_back(make_reply(RK_ACK, idx, relay_up[idx], '0, '0, 1'b1,
                                                1'b0));
          end
        end
        KIND_SYNC: begin
          if (link_up)
            for (int i = 0; i < RELAYS; i++)
              step_replies.push_back(make_reply(RK_ACK, 2'(i), relay_up[i], '0, '0, 1'b0,
                                                1'b0));
        end
        default: begin
          hrs = m.now / MS_PER_HOUR;
          if (link_up)
            step_replies.push_back(make_reply(RK_PONG, '0, 1'b0, hrs[15:0], '0, 1'b0, 1'b0));
        end
      endcase
    end
    // drive reflects the bank after the whole word
    foreach (step_replies[i])
      step_replies[i].drive = relay_up;
    if (step_replies.size() > 0)
      step_replies[step_replies.size() - 1].last = 1'b1;
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_GATEWAY:  gw_addr     = value[15:0];
      REG_MAX_ON:   clamp_ms    = value;
      REG_ANNOUNCE: announce_ms = value;
      REG_LINK:     link_up     = value[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // sender works in bursts; an accepted word is run through the model at once
  task automatic send_msg(input relay_msg_t m, input int fixed_n, input reply_t fixed);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    kind_i           <= m.kind;
    source_address_i <= m.src;
    frame_length_i   <= m.flen;
    relay_index_i    <= m.rid;
    command_i        <= m.cmd;
    duration_ms_i    <= m.dur;
    now_ms_i         <= m.now;
    do @(posedge clk_i); while (!in_ready_o);
    predict_replies(m);
    if (fixed_n == PREDICTED) begin
      foreach (step_replies[i]) expected_replies.push_back(step_replies[i]);
    end else if (fixed_n == 1) begin
      expected_replies.push_back(fixed);
    end
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void add_row(int link_before, logic [1:0] kind, logic [15:0] src,
                                  logic [7:0] flen, logic [7:0] rid, cmd_e cmd,
                                  logic [31:0] dur, logic [31:0] now, int fixed_n,
                                  reply_t fixed);
    script_row_t row;
    row.link_before = link_before;
    row.msg.kind    = kind;
    row.msg.src     = src;
    row.msg.flen    = flen;
    row.msg.rid     = rid;
    row.msg.cmd     = cmd;
    row.msg.dur     = dur;
    row.msg.now     = now;
    row.fixed_n     = fixed_n;
    row.fixed       = fixed;
    script.push_back(row);
  endfunction

  function automatic relay_msg_t random_msg();
    relay_msg_t m;
    int pick;
    pick   = $urandom_range(0, 99);
    m.kind = (pick < 35) ? KIND_TICK : (pick < 75) ? KIND_CMD :
             (pick < 85) ? KIND_SYNC : KIND_PING;
    m.src  = ($urandom_range(0, 99) < 85) ? gw_addr : 16'($urandom);
    pick   = $urandom_range(0, 99);
    m.flen = (pick < 80) ? 8'($urandom_range(MIN_CMD_LEN, 255)) :
             (pick < 90) ? 8'd0 : 8'($urandom_range(1, MIN_CMD_LEN - 1));
    m.rid  = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, RELAYS - 1)) :
                                            8'($urandom_range(RELAYS, 255));
    m.cmd  = cmd_e'(2'($urandom_range(0, 3)));
    pick   = $urandom_range(0, 99);
    m.dur  = (pick < 20) ? 32'd0 : (pick < 70) ? 32'($urandom_range(1, 4000)) :
             (pick < 80) ? 32'($urandom_range(1, 10000)) :
             (pick < 95) ? 32'($urandom) : 32'hFFFF_FFFF;
    pick   = $urandom_range(0, 99);
    if (pick < 70)      sim_clock_ms += $urandom_range(0, 1500);
    else if (pick < 90) sim_clock_ms += $urandom_range(0, 20000);
    else if (pick < 95) sim_clock_ms += $urandom;
    // last few percent: a stray timestamp that leaves the running clock alone
    m.now = (pick < 95) ? sim_clock_ms : 32'($urandom);
    return m;
  endfunction

  initial begin : stimulus
    int          phase_words[5];
    logic [15:0] gw;
    logic [30:0] mx;
    logic [30:0] an;
    logic        lk;
    reply_t      none;
    none = '0;
    phase_words = '{70, 60, 60, 30, 80};

    // registers at reset values, gateway 0
    add_row(NO_LINK_WRITE, KIND_PING, 16'h0000, 8'd1, 8'd0, CMD_ON, 32'd0, 32'd0,
            1, make_reply(RK_PONG, 2'd0, 1'b0, 16'd0, 4'b0000, 1'b0, 1'b1));
    add_row(NO_LINK_WRITE, KIND_PING, 16'h0000, 8'd1, 8'd0, CMD_ON, 32'd0, 32'hFFFF_FFFF,
            1, make_reply(RK_PONG, 2'd0, 1'b0, 16'd1193, 4'b0000, 1'b0, 1'b1));
    add_row(NO_LINK_WRITE, KIND_TICK, 16'h0000, 8'd0, 8'd0, CMD_ON, 32'd0, 32'd0,
            0, none);
    // foreign sender, empty frame, short command, relay index out of range
    add_row(NO_LINK_WRITE, KIND_CMD, 16'hFFFF, 8'd255, 8'd0, CMD_ON, 32'd0, 32'd10,
            0, none);
    add_row(NO_LINK_WRITE, KIND_CMD, 16'h0000, 8'd0, 8'd0, CMD_ON, 32'd0, 32'd10,
            0, none);
    add_row(NO_LINK_WRITE, KIND_CMD, 16'h0000, 8'd6, 8'd0, CMD_ON, 32'd0, 32'd10,
            0, none);
    add_row(NO_LINK_WRITE, KIND_CMD, 16'h0000, 8'd7, 8'd4, CMD_ON, 32'd0, 32'd10,
            0, none);
    add_row(NO_LINK_WRITE, KIND_CMD, 16'h0000, 8'd255, 8'd255, CMD_TOGGLE, 32'd0, 32'd10,
            0, none);
    add_row(NO_LINK_WRITE, KIND_CMD, 16'h0000, 8'd7, 8'd0, CMD_ON, 32'd1000, 32'd100,
            1, make_reply(RK_ACK, 2'd0, 1'b1, 16'd0, 4'b0001, 1'b1, 1'b1));
    // on without duration keeps the armed timer
    add_row(NO_LINK_WRITE, KIND_CMD, 16'h0000, 8'd7, 8'd0, CMD_ON, 32'd0, 32'd200,
            PREDICTED, none);
    // duration far above the clamp
    add_row(NO_LINK_WRITE, KIND_CMD, 16'h0000, 8'd7, 8'd1, CMD_ON, 32'hFFFF_FFFF, 32'd300,
            1, make_reply(RK_ACK, 2'd1, 1'b1, 16'd0, 4'b0011, 1'b1, 1'b1));
    add_row(NO_LINK_WRITE, KIND_CMD, 16'h0000, 8'd7, 8'd2, CMD_TOGGLE, 32'd500, 32'd400,
            PREDICTED, none);
    add_row(NO_LINK_WRITE, KIND_CMD, 16'h0000, 8'd7, 8'd2, CMD_TOGGLE, 32'd0, 32'd410,
            PREDICTED, none);
    // toggle back on with no duration clears the timer
    add_row(NO_LINK_WRITE, KIND_CMD, 16'h0000, 8'd7, 8'd2, CMD_TOGGLE, 32'd0, 32'd420,
            PREDICTED, none);
    add_row(NO_LINK_WRITE, KIND_CMD, 16'h0000, 8'd7, 8'd3, CMD_UNKNOWN, 32'd50, 32'd430,
            PREDICTED, none);
    add_row(NO_LINK_WRITE, KIND_SYNC, 16'h0000, 8'd1, 8'd0, CMD_ON, 32'd0, 32'd440,
            PREDICTED, none);
    // tick behind the arm time: negative difference, nothing expires
    add_row(NO_LINK_WRITE, KIND_TICK, 16'h0000, 8'd0, 8'd0, CMD_ON, 32'd0, 32'd50,
            PREDICTED, none);
    add_row(NO_LINK_WRITE, KIND_TICK, 16'h0000, 8'd0, 8'd0, CMD_ON, 32'd0, 32'd1100,
            PREDICTED, none);
    add_row(NO_LINK_WRITE, KIND_TICK, 16'h0000, 8'd0, 8'd0, CMD_ON, 32'd0, 32'd60000,
            PREDICTED, none);
    add_row(NO_LINK_WRITE, KIND_CMD, 16'h0000, 8'd7, 8'd1, CMD_OFF, 32'd0, 32'd60010,
            PREDICTED, none);
    // timer armed just before the wrap, expires just after
    add_row(NO_LINK_WRITE, KIND_CMD, 16'h0000, 8'd7, 8'd3, CMD_ON, 32'd1, 32'hFFFF_FFFF,
            PREDICTED, none);
    add_row(NO_LINK_WRITE, KIND_TICK, 16'h0000, 8'd0, 8'd0, CMD_ON, 32'd0, 32'd0,
            PREDICTED, none);
    // link down: state still moves, nothing comes out, the announce stays due
    add_row(0, KIND_TICK, 16'h0000, 8'd0, 8'd0, CMD_ON, 32'd0, 32'd200000,
            PREDICTED, none);
    add_row(NO_LINK_WRITE, KIND_CMD, 16'h0000, 8'd7, 8'd0, CMD_ON, 32'd10, 32'd200000,
            PREDICTED, none);
    add_row(NO_LINK_WRITE, KIND_PING, 16'h0000, 8'd1, 8'd0, CMD_ON, 32'd0, 32'd200000,
            PREDICTED, none);
    add_row(NO_LINK_WRITE, KIND_TICK, 16'h0000, 8'd0, 8'd0, CMD_ON, 32'd0, 32'd200010,
            PREDICTED, none);
    add_row(1, KIND_TICK, 16'h0000, 8'd0, 8'd0, CMD_ON, 32'd0, 32'd200020,
            PREDICTED, none);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].link_before != NO_LINK_WRITE) begin
        drain_and_settle();
        set_register(REG_LINK, 31'(script[i].link_before));
      end
      send_msg(script[i].msg, script[i].fixed_n, script[i].fixed);
    end

    for (int p = 0; p < 5; p++) begin
      drain_and_settle();
      case (p)
        0: begin
          gw = 16'h5A3C; mx = 31'd5000; an = 31'd3000; lk = 1'b1;
          sim_clock_ms = 32'd250000;
        end
        1: begin
          gw = 16'hFFFF; mx = 31'h7FFF_FFFF; an = 31'h7FFF_FFFF; lk = 1'b1;
          sim_clock_ms = 32'hFFFF_0000;
        end
        2: begin
          gw = 16'h0000; mx = 31'd0; an = 31'd0; lk = 1'b1;
          sim_clock_ms = $urandom;
        end
        3: begin
          gw = 16'($urandom); mx = 31'($urandom_range(1, 20000));
          an = 31'($urandom_range(1, 20000)); lk = 1'b0;
          sim_clock_ms = $urandom;
        end
        default: begin
          gw = 16'($urandom); mx = 31'($urandom_range(100, 5000));
          an = 31'($urandom_range(1000, 10000)); lk = 1'b1;
          sim_clock_ms = $urandom;
        end
      endcase
      set_register(REG_GATEWAY, 31'(gw));
      set_register(REG_MAX_ON, mx);
      set_register(REG_ANNOUNCE, an);
      set_register(REG_LINK, 31'(lk));
      // long reply hold-off while words keep coming
      if (p == 0) hold_asked++;
      repeat (phase_words[p]) send_msg(random_msg(), PREDICTED, none);
    end

    drain_and_settle();
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  task automatic check_reply();
    reply_t got;
    reply_t want;
    got = make_reply(result_kind_o, acked_relay_o, acked_state_o, uptime_hours_o,
                     relay_drive_o, blink_o, last_o);
    if (expected_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected word: kind=%0d relay=%0d state=%0d hours=%0d drive=%h",
                 got.kind, got.relay, got.state, got.hours, got.drive);
    end else begin
      want = expected_replies.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch exp: kind=%0d rly=%0d st=%0d hrs=%0d drv=%h blk=%0d last=%0d",
                   want.kind, want.relay, want.state, want.hours, want.drive, want.blink,
                   want.last);
          $display("         got: kind=%0d rly=%0d st=%0d hrs=%0d drv=%h blk=%0d last=%0d",
                   got.kind, got.relay, got.state, got.hours, got.drive, got.blink,
                   got.last);
        end
      end
    end
  endtask

  // reply side: stall pattern switches at random among four modes
  initial begin : reply_sink
    int mode;
    int mode_left;
    int hold_left;
    int hold_seen;
    int cyc;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    cyc       = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) check_reply();
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      cyc++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ((cyc % 6) < 3);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_top failed");
    $finish;
  end

endmodule
